FILE: design/sltg_pkg.sv
`default_nettype none

package sltg_pkg;

   localparam int SENDERS = 8;
   localparam int SLOT_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1;

   localparam int SPEED_W    = 16;
   localparam int THROTTLE_W = 16;
   localparam int TIME_W     = 32;
   localparam int MAX_SPD_W  = 15;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_LIMIT    = 2'd0,
      CMD_WHEEL    = 2'd1,
      CMD_THROTTLE = 2'd2
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_MAX_SAFE_SPEED = 1'b0,
      CSR_LIMIT_TIMEOUT  = 1'b1
   } csr_type;

   typedef struct packed {
      logic write_limit;
      logic write_wheel;
      logic start_scan;
      logic scan_step;
      logic decide;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: design/speed_limit_throttle_governor_top.sv
// Speed-limit throttle governor. A limit update (cmd 0) or wheel sample (cmd 1) is
// taken while idle and gives no result; cmd 3 is dropped. A throttle request
// (cmd 2) walks the sender slots one per cycle through a single age comparator
// and minimum unit, then decides: the result is written to the output register
// in the decide step, after the last slot, and only then does the block return
// to idle and take the next item, so a request is never overlapped with the next.
// The decide step holds while an earlier result still waits in the output
// register; the next item may be accepted while a result waits to be taken.
// Configuration registers are written on csr_we: index 0 max_safe_speed (15 bits),
// index 1 limit_timeout (16 bits).
`default_nettype none

module speed_limit_throttle_governor_top import sltg_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [0:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic [2:0]                   req_sender_index,
   input  logic [TIME_W-1:0]            req_time_stamp,
   input  logic signed [SPEED_W-1:0]    req_limit_speed,
   input  logic signed [SPEED_W-1:0]    req_left_front_speed,
   input  logic signed [SPEED_W-1:0]    req_right_front_speed,
   input  logic signed [THROTTLE_W-1:0] req_throttle_command,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [THROTTLE_W-1:0] rsp_safe_throttle,
   output logic                         rsp_governor_active,
   output logic                         rsp_safe_speed_valid,
   output logic signed [SPEED_W-1:0]    rsp_safe_speed
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   sltg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   sltg_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .dp_cmd                (dp_cmd),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_sender_index      (req_sender_index),
      .req_time_stamp        (req_time_stamp),
      .req_limit_speed       (req_limit_speed),
      .req_left_front_speed  (req_left_front_speed),
      .req_right_front_speed (req_right_front_speed),
      .req_throttle_command  (req_throttle_command),
      .rsp_safe_throttle     (rsp_safe_throttle),
      .rsp_governor_active   (rsp_governor_active),
      .rsp_safe_speed_valid  (rsp_safe_speed_valid),
      .rsp_safe_speed        (rsp_safe_speed)
   );

endmodule

`default_nettype wire

FILE: design/sltg_ctrl.sv
`default_nettype none

module sltg_ctrl import sltg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LIMIT: dp_cmd.write_limit = 1'b1;
                  CMD_WHEEL: dp_cmd.write_wheel = 1'b1;
                  CMD_THROTTLE: begin
                     dp_cmd.start_scan = 1'b1;
                     state_in          = ST_SCAN;
                  end
                  default: ;  // unused command: drop the item
               endcase
            end
         end
         ST_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold until the output register can take the result
            if (out_free) begin
               dp_cmd.decide = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/sltg_dp.sv
`default_nettype none

module sltg_dp import sltg_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   dp_cmd,
   output dp_status_type                status,
   input  logic                         csr_we,
   input  logic [0:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic [2:0]                   req_sender_index,
   input  logic [TIME_W-1:0]            req_time_stamp,
   input  logic signed [SPEED_W-1:0]    req_limit_speed,
   input  logic signed [SPEED_W-1:0]    req_left_front_speed,
   input  logic signed [SPEED_W-1:0]    req_right_front_speed,
   input  logic signed [THROTTLE_W-1:0] req_throttle_command,
   output logic signed [THROTTLE_W-1:0] rsp_safe_throttle,
   output logic                         rsp_governor_active,
   output logic                         rsp_safe_speed_valid,
   output logic signed [SPEED_W-1:0]    rsp_safe_speed
);

   logic [MAX_SPD_W-1:0] max_speed_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [SENDERS-1:0]         present_ff;
   logic signed [SPEED_W-1:0]  entry_speed_ff [SENDERS];
   logic [TIME_W-1:0]          entry_time_ff  [SENDERS];

   logic signed [SPEED_W-1:0]    latest_speed_ff;
   logic [1:0]                   sample_count_ff;
   logic                         in_control_ff, in_control_in;
   logic signed [THROTTLE_W-1:0] prev_good_ff, prev_good_in;

   logic [SLOT_W-1:0]            idx_ff;
   logic [TIME_W-1:0]            now_ff;
   logic signed [THROTTLE_W-1:0] thr_ff;
   logic signed [SPEED_W-1:0]    limit_ff, limit_in;
   logic                         valid_ff;

   logic signed [THROTTLE_W-1:0] result_in;
   logic signed [THROTTLE_W-1:0] out_throttle_ff;
   logic                         out_active_ff;
   logic                         out_valid_ff;
   logic signed [SPEED_W-1:0]    out_speed_ff;

   logic [7:0]                slot_wide;
   logic                      slot_ok;
   logic signed [SPEED_W:0]   wheel_sum;
   logic [TIME_W-1:0]         age;
   logic signed [SPEED_W-1:0] cur_speed;
   logic                      hit;
   logic                      allowed;
   logic                      ctl_kept;

   assign slot_wide = {5'b0, req_sender_index};
   assign slot_ok   = (slot_wide < 8'(SENDERS));
   assign wheel_sum = {req_left_front_speed[SPEED_W-1], req_left_front_speed}
                    + {req_right_front_speed[SPEED_W-1], req_right_front_speed};

   assign status.scan_last = (idx_ff == SLOT_W'(SENDERS - 1));

   // one slot per cycle: age and running minimum
   assign cur_speed = entry_speed_ff[idx_ff];
   assign age       = now_ff - entry_time_ff[idx_ff];
   assign hit       = present_ff[idx_ff] && (age < {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ff});
   assign limit_in  = (hit && (cur_speed < limit_ff)) ? cur_speed : limit_ff;

   assign allowed = valid_ff && (limit_ff > 0) && (sample_count_ff == 2'd2);

   always_comb begin
      in_control_in = in_control_ff;
      prev_good_in  = prev_good_ff;
      result_in     = '0;
      ctl_kept      = in_control_ff && !(thr_ff < prev_good_ff);
      if (allowed) begin
         in_control_in = ctl_kept;
         if (!ctl_kept) begin
            if (latest_speed_ff < limit_ff) begin
               result_in = thr_ff;
            end else begin
               prev_good_in  = thr_ff;
               in_control_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff    <= '0;
         timeout_ff      <= '0;
         present_ff      <= '0;
         latest_speed_ff <= '0;
         sample_count_ff <= '0;
         in_control_ff   <= 1'b0;
         prev_good_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_SAFE_SPEED: max_speed_ff <= csr_wdata[MAX_SPD_W-1:0];
               CSR_LIMIT_TIMEOUT:  timeout_ff   <= csr_wdata[TIMEOUT_W-1:0];
            endcase
         end
         if (dp_cmd.write_limit && slot_ok) begin
            present_ff[slot_wide[SLOT_W-1:0]] <= 1'b1;
         end
         if (dp_cmd.write_wheel) begin
            latest_speed_ff <= wheel_sum[SPEED_W:1];
            if (sample_count_ff != 2'd2) begin
               sample_count_ff <= sample_count_ff + 2'd1;
            end
         end
         if (dp_cmd.decide) begin
            in_control_ff <= in_control_in;
            prev_good_ff  <= prev_good_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.write_limit && slot_ok) begin
         entry_speed_ff[slot_wide[SLOT_W-1:0]] <= req_limit_speed;
         entry_time_ff[slot_wide[SLOT_W-1:0]]  <= req_time_stamp;
      end
      if (dp_cmd.start_scan) begin
         idx_ff   <= '0;
         now_ff   <= req_time_stamp;
         thr_ff   <= req_throttle_command;
         limit_ff <= SPEED_W'(max_speed_ff);
         valid_ff <= 1'b0;
      end else if (dp_cmd.scan_step) begin
         idx_ff   <= idx_ff + SLOT_W'(1);
         limit_ff <= limit_in;
         valid_ff <= valid_ff || hit;
      end
      if (dp_cmd.decide) begin
         out_throttle_ff <= result_in;
         out_active_ff   <= in_control_in;
         out_valid_ff    <= valid_ff;
         out_speed_ff    <= valid_ff ? limit_ff : '0;
      end
   end

   assign rsp_safe_throttle    = out_throttle_ff;
   assign rsp_governor_active  = out_active_ff;
   assign rsp_safe_speed_valid = out_valid_ff;
   assign rsp_safe_speed       = out_speed_ff;

endmodule

`default_nettype wire

FILE: design/sltg_checker.sv
`default_nettype none

module sltg_checker import sltg_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [THROTTLE_W-1:0] rsp_safe_throttle,
   input logic                         rsp_governor_active,
   input logic                         rsp_safe_speed_valid,
   input logic signed [SPEED_W-1:0]    rsp_safe_speed
);

   // a stalled item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_safe_throttle)
         && $stable(rsp_safe_speed) && $stable(rsp_governor_active))
      else $error("rsp item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_safe_speed_valid |-> rsp_safe_speed == '0)
      else $error("safe_speed nonzero with no valid limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_governor_active |-> rsp_safe_throttle == '0)
      else $error("throttle passed while governor active");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_safe_speed_valid |-> rsp_safe_throttle == '0)
      else $error("throttle passed with no valid limit");

endmodule

bind speed_limit_throttle_governor_top sltg_checker u_sltg_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_safe_throttle    (rsp_safe_throttle),
   .rsp_governor_active  (rsp_governor_active),
   .rsp_safe_speed_valid (rsp_safe_speed_valid),
   .rsp_safe_speed       (rsp_safe_speed)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sltg_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [2:0]          slot;
      logic [31:0]         stamp;
      logic signed [15:0]  limit_spd;
      logic signed [15:0]  left_spd;
      logic signed [15:0]  right_spd;
      logic signed [15:0]  throttle;
   } gov_item_type;

   typedef struct packed {
      logic signed [15:0]  safe_throttle;
      logic                governor_active;
      logic                speed_valid;
      logic signed [15:0]  safe_speed;
   } gov_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [0:0]                   csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_cmd = '0;
   logic [2:0]                   req_sender_index = '0;
   logic [TIME_W-1:0]            req_time_stamp = '0;
   logic signed [SPEED_W-1:0]    req_limit_speed = '0;
   logic signed [SPEED_W-1:0]    req_left_front_speed = '0;
   logic signed [SPEED_W-1:0]    req_right_front_speed = '0;
   logic signed [THROTTLE_W-1:0] req_throttle_command = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [THROTTLE_W-1:0] rsp_safe_throttle;
   logic                         rsp_governor_active;
   logic                         rsp_safe_speed_valid;
   logic signed [SPEED_W-1:0]    rsp_safe_speed;

   speed_limit_throttle_governor_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_sender_index      (req_sender_index),
      .req_time_stamp        (req_time_stamp),
      .req_limit_speed       (req_limit_speed),
      .req_left_front_speed  (req_left_front_speed),
      .req_right_front_speed (req_right_front_speed),
      .req_throttle_command  (req_throttle_command),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_safe_throttle     (rsp_safe_throttle),
      .rsp_governor_active   (rsp_governor_active),
      .rsp_safe_speed_valid  (rsp_safe_speed_valid),
      .rsp_safe_speed        (rsp_safe_speed)
   );

   // governor state as the block should hold it
   logic [14:0]         cfg_max_speed = '0;
   logic [15:0]         cfg_timeout = '0;
   logic [SENDERS-1:0]  slot_present = '0;
   logic signed [15:0]  slot_speed [SENDERS];
   logic [31:0]         slot_stamp [SENDERS];
   logic signed [15:0]  wheel_speed = '0;
   int unsigned         wheel_samples = 0;
   logic                governing = 1'b0;
   logic signed [15:0]  saved_throttle = '0;

   gov_item_type        pending_items [$];
   gov_result_type      governed_q [$];
   gov_item_type        drive_item;
   gov_result_type      exp_res;
   gov_result_type      got_res;
   logic [31:0]         now_ms = '0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         err_count = 0;
   int unsigned         quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void govern_step(input gov_item_type it);
      int                 lim;
      int                 sum;
      logic [31:0]        age;
      logic               any_valid;
      logic signed [15:0] thr_out;
      gov_result_type     res;
      case (it.cmd)
         CMD_LIMIT: begin
            slot_speed[it.slot]   = it.limit_spd;
            slot_stamp[it.slot]   = it.stamp;
            slot_present[it.slot] = 1'b1;
         end
         CMD_WHEEL: begin
            // arithmetic shift floors toward minus infinity
            sum = int'($signed(it.left_spd)) + int'($signed(it.right_spd));
            wheel_speed = 16'(sum >>> 1);
            if (wheel_samples < 2) begin
               wheel_samples++;
            end
         end
         CMD_THROTTLE: begin
            lim = int'(cfg_max_speed);
            any_valid = 1'b0;
            thr_out = '0;
            for (int i = 0; i < SENDERS; i++) begin
               if (slot_present[i]) begin
                  age = it.stamp - slot_stamp[i];
                  if (age < 32'(cfg_timeout)) begin
                     if ($signed(slot_speed[i]) < lim) begin
                        lim = $signed(slot_speed[i]);
                     end
                     any_valid = 1'b1;
                  end
               end
            end
            if (any_valid && lim > 0 && wheel_samples >= 2) begin
               if (governing && $signed(it.throttle) < saved_throttle) begin
                  governing = 1'b0;
               end
               if (!governing) begin
                  if (wheel_speed < lim) begin
                     thr_out = it.throttle;
                  end else begin
                     saved_throttle = it.throttle;
                     governing = 1'b1;
                  end
               end
            end
            res.safe_throttle   = thr_out;
            res.governor_active = governing;
            res.speed_valid     = any_valid;
            res.safe_speed      = any_valid ? 16'(lim) : 16'sd0;
            governed_q = {governed_q, res};
         end
         default: ;
      endcase
   endfunction

   function automatic void note_error(input string msg);
      err_count++;
      if (err_count <= 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void push_item(input logic [1:0] cmd, input int slot,
                                     input logic [31:0] stamp, input int lim,
                                     input int left, input int right, input int thr);
      gov_item_type it;
      it.cmd       = cmd;
      it.slot      = 3'(slot);
      it.stamp     = stamp;
      it.limit_spd = 16'(lim);
      it.left_spd  = 16'(left);
      it.right_spd = 16'(right);
      it.throttle  = 16'(thr);
      pending_items = {pending_items, it};
   endfunction

   // mostly plausible traffic around the current time, a few raw items
   function automatic gov_item_type random_item();
      gov_item_type it;
      int unsigned  pick;
      int unsigned  span;
      int           base;
      it.cmd       = 2'($urandom_range(3));
      it.slot      = 3'($urandom);
      it.stamp     = $urandom;
      it.limit_spd = 16'($urandom);
      it.left_spd  = 16'($urandom);
      it.right_spd = 16'($urandom);
      it.throttle  = 16'($urandom);
      span = (cfg_timeout == 0) ? 64 : cfg_timeout;
      pick = $urandom_range(99);
      if (pick < 6) begin
         return it;
      end
      now_ms += $urandom_range(0, span / 6 + 1);
      if (pick < 36) begin
         it.cmd = CMD_LIMIT;
         if ($urandom_range(9) == 0) begin
            it.stamp = now_ms + $urandom_range(1, 200);
         end else begin
            it.stamp = now_ms - $urandom_range(0, span + span / 2);
         end
         if ($urandom_range(19) == 0) begin
            it.limit_spd = 16'(-int'($urandom_range(0, 500)));
         end else begin
            it.limit_spd = 16'($urandom_range(1000, 9000));
         end
      end else if (pick < 64) begin
         it.cmd = CMD_WHEEL;
         base = int'($urandom_range(0, 10000));
         it.left_spd  = 16'(base + int'($urandom_range(0, 200)) - 100);
         it.right_spd = 16'(base + int'($urandom_range(0, 200)) - 100);
      end else begin
         it.cmd   = CMD_THROTTLE;
         it.stamp = now_ms;
         if ($urandom_range(9) != 0) begin
            it.throttle = 16'(int'($urandom_range(0, 32768)) - 16384);
         end
      end
      return it;
   endfunction

   task automatic write_csr(input csr_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_SAFE_SPEED) begin
         cfg_max_speed = val[14:0];
      end else begin
         cfg_timeout = val;
      end
   endtask

   // hold until every item is taken and every result is back, then let the
   // block finish any update still in flight
   task automatic settle();
      while (pending_items.size() != 0 || req_valid || governed_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int unsigned idle_pct,
                            input int unsigned stall_pct, input logic [15:0] max_val,
                            input logic [15:0] tmo_val, input logic [31:0] start_ms);
      settle();
      write_csr(CSR_MAX_SAFE_SPEED, max_val);
      write_csr(CSR_LIMIT_TIMEOUT, tmo_val);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      now_ms = start_ms;
      repeat (count) pending_items = {pending_items, random_item()};
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            govern_step(drive_item);
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = pending_items.pop_front();
               req_valid             <= 1'b1;
               req_cmd               <= drive_item.cmd;
               req_sender_index      <= drive_item.slot;
               req_time_stamp        <= drive_item.stamp;
               req_limit_speed       <= drive_item.limit_spd;
               req_left_front_speed  <= drive_item.left_spd;
               req_right_front_speed <= drive_item.right_spd;
               req_throttle_command  <= drive_item.throttle;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_res.safe_throttle   = rsp_safe_throttle;
            got_res.governor_active = rsp_governor_active;
            got_res.speed_valid     = rsp_safe_speed_valid;
            got_res.safe_speed      = rsp_safe_speed;
            if (governed_q.size() == 0) begin
               note_error("result with no throttle request pending");
            end else begin
               exp_res = governed_q.pop_front();
               if (got_res.safe_throttle !== exp_res.safe_throttle ||
                   got_res.governor_active !== exp_res.governor_active ||
                   got_res.speed_valid !== exp_res.speed_valid ||
                   got_res.safe_speed !== exp_res.safe_speed) begin
                  note_error($sformatf({"expected throttle %0d active %0b valid %0b",
                     " speed %0d, got throttle %0d active %0b valid %0b speed %0d"},
                     exp_res.safe_throttle, exp_res.governor_active,
                     exp_res.speed_valid, exp_res.safe_speed,
                     got_res.safe_throttle, got_res.governor_active,
                     got_res.speed_valid, got_res.safe_speed));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] t0;
      t0 = 32'hFFFF_FFC0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_MAX_SAFE_SPEED, 16'd20000);
      write_csr(CSR_LIMIT_TIMEOUT, 16'd1000);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // no slot yet, then a slot but too few wheel samples
      push_item(CMD_THROTTLE, 0, t0, 0, 0, 0, 1000);
      push_item(CMD_LIMIT, 0, t0, 3000, 0, 0, 0);
      push_item(CMD_THROTTLE, 0, t0 + 10, 0, 0, 0, 1000);
      // wheel extremes and floor of an odd negative sum
      push_item(CMD_WHEEL, 0, 0, 0, 32767, 32767, 0);
      push_item(CMD_WHEEL, 0, 0, 0, -32768, -32768, 0);
      push_item(CMD_WHEEL, 0, 0, 0, -3, 0, 0);
      push_item(CMD_THROTTLE, 0, t0 + 20, 0, 0, 0, 16384);
      push_item(CMD_THROTTLE, 0, t0 + 20, 0, 0, 0, -16384);
      // negative limit blocks the request
      push_item(CMD_LIMIT, 7, t0 + 30, -32768, 0, 0, 0);
      push_item(CMD_THROTTLE, 0, t0 + 40, 0, 0, 0, 500);
      push_item(CMD_LIMIT, 7, t0 + 50, 32767, 0, 0, 0);
      // overspeed latches, a lower command releases
      push_item(CMD_WHEEL, 0, 0, 0, 5000, 5001, 0);
      push_item(CMD_THROTTLE, 0, t0 + 60, 0, 0, 0, 8000);
      push_item(CMD_THROTTLE, 0, t0 + 60, 0, 0, 0, 9000);
      push_item(CMD_WHEEL, 0, 0, 0, 100, 101, 0);
      push_item(CMD_THROTTLE, 0, t0 + 70, 0, 0, 0, 7000);
      // stamp ahead of now wraps to a huge age
      push_item(CMD_LIMIT, 3, t0 + 2000, 1000, 0, 0, 0);
      push_item(CMD_THROTTLE, 0, t0 + 80, 0, 0, 0, 32767);
      // age equal to the timeout no longer counts
      push_item(CMD_THROTTLE, 0, t0 + 1000, 0, 0, 0, -32768);
      push_item(CMD_UNUSED, 5, $urandom, $urandom, $urandom, $urandom, $urandom);
      // zero limit blocks the request
      push_item(CMD_LIMIT, 5, t0 + 1000, 0, 0, 0, 0);
      push_item(CMD_THROTTLE, 0, t0 + 1001, 0, 0, 0, 1234);

      run_phase(150, 0, 0, 16'd32767, 16'hFFFF, 32'hFFFF_F000);
      run_phase(150, 86, 0, 16'd6000, 16'd300, $urandom);
      run_phase(150, 0, 86, 16'($urandom_range(2000, 20000)),
                16'($urandom_range(50, 2000)), $urandom);
      run_phase(150, 6, 6, 16'd0, 16'd800, $urandom);
      run_phase(100, 0, 0, 16'd5000, 16'd0, $urandom);
      run_phase(100, 86, 86, 16'($urandom_range(1000, 9000)), 16'd1, $urandom);
      run_phase(150, 6, 6, 16'hFFFF, 16'd400, $urandom);
      settle();

      if (err_count == 0 && governed_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/sltg_pkg.sv
design/sltg_ctrl.sv
design/sltg_dp.sv
design/speed_limit_throttle_governor_top.sv
design/sltg_checker.sv
tb/tb_top.sv
